// File: rtl/afdrl_pkg.sv
// Shared types, constants and lookup functions for the alert debounce / rate limiter.
// No dependencies; compiled first.
package afdrl_pkg;

   typedef logic [4:0]  etype_type;
   typedef logic [7:0]  pack_type;
   typedef logic [31:0] ms_type;
   typedef logic [1:0]  sev_type;
   typedef logic [2:0]  csr_index_type;
   typedef logic [31:0] csr_data_type;

   localparam etype_type MAX_TYPE = 5'd17;
   localparam logic [16:0] FLOOR_S = 17'd60;
   localparam ms_type FLOOR_MS = 32'd60000;
   localparam ms_type MS_PER_S = 32'd1000;

   typedef enum logic [2:0] {
      REG_DEBOUNCE = 3'd0,
      REG_GLOBAL   = 3'd1,
      REG_COOLDOWN = 3'd2,
      REG_MASK     = 3'd3,
      REG_ENABLE   = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_FLUSH  = 2'd0,
      MODE_CLEAR  = 2'd1,
      MODE_BEGIN  = 2'd2,
      MODE_SINGLE = 2'd3
   } mode_type;

   function automatic sev_type sev_of(etype_type t);
      sev_type s;
      case (t)
         5'd1, 5'd9, 5'd11, 5'd13:          s = 2'd1;
         5'd3, 5'd5, 5'd7, 5'd15, 5'd16:    s = 2'd2;
         default:                           s = 2'd0;
      endcase
      return s;
   endfunction

   // begin type that a clear cancels; zero for begin events
   function automatic etype_type begin_of(etype_type t);
      etype_type b;
      case (t)
         5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14: b = t - 5'd1;
         5'd17:                                       b = 5'd16;
         default:                                     b = 5'd0;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/afdrl_if.sv
// Handshake channel interfaces: event input, alert output, register writes.
// Depends on afdrl_pkg.
interface afdrl_req_if;
   logic                 valid;
   logic                 ready;
   logic                 kind;
   afdrl_pkg::etype_type event_type;
   afdrl_pkg::pack_type  pack_id;
   afdrl_pkg::ms_type    now_ms;
   modport source (output valid, kind, event_type, pack_id, now_ms, input ready);
   modport sink   (input valid, kind, event_type, pack_id, now_ms, output ready);
endinterface

interface afdrl_rsp_if;
   logic                 valid;
   logic                 ready;
   afdrl_pkg::etype_type alert_type;
   afdrl_pkg::pack_type  alert_pack;
   afdrl_pkg::sev_type   severity;
   logic                 notify;
   afdrl_pkg::ms_type    dropped_total;
   logic                 last;
   modport source (output valid, alert_type, alert_pack, severity, notify, dropped_total,
                   last, input ready);
   modport sink   (input valid, alert_type, alert_pack, severity, notify, dropped_total,
                   last, output ready);
endinterface

interface afdrl_csr_if;
   logic                     valid;
   logic                     ready;
   afdrl_pkg::csr_index_type index;
   afdrl_pkg::csr_data_type  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/alert_flap_debounce_rate_limiter.sv
// Alert debounce table, flap cancel and notification rate limiter (top level).
// Depends on afdrl_pkg and the channel interfaces in afdrl_if.sv.
//
//   channel   direction  payload
//   req_ch    in         kind, event_type, pack_id, now_ms
//   rsp_ch    out        alert_type, alert_pack, severity, notify, dropped_total, last
//   csr_ch    in         index, data (always ready)
//
// One item at a time. A table scan reads one slot per cycle from the pending memory
// (registered read); a flush scan pauses at each expired entry to emit its alert.
// An immediate event goes from idle through emit and finish; an ignored item or a flush
// with no debounce stays in idle without a scan.
// A stalled rsp_ch holds the sequencer only when a new alert must go out.
// Synchronous reset clears the valid bits, timestamps and drop count.
module alert_flap_debounce_rate_limiter #(
   parameter int TABLE_SLOTS = 32,
   parameter int EVENT_TYPES = 18
) (
   input logic          clock,
   input logic          reset,
   afdrl_req_if.sink    req_ch,
   afdrl_rsp_if.source  rsp_ch,
   afdrl_csr_if.sink    csr_ch
);
   import afdrl_pkg::*;

   localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int TW = (EVENT_TYPES > 1) ? $clog2(EVENT_TYPES) : 1;
   localparam logic [IW:0] SLOT_END = (IW+1)'(TABLE_SLOTS);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_EMIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      etype_type etype;
      pack_type  pack;
      ms_type    start;
   } entry_type;

   // configuration, kept in milliseconds
   ms_type       deb_ms_ff, gap_ms_ff, cool_ms_ff;
   logic [17:0]  mask_ff;
   logic         enable_ff;

   state_type    state_ff, state_in;
   mode_type     mode_ff;
   etype_type    ty_ff, pb_ff;
   pack_type     pack_ff;
   ms_type       now_ff;

   entry_type    mem [TABLE_SLOTS];
   entry_type    rd_ff;
   logic [TABLE_SLOTS-1:0] pv_ff;
   logic [IW:0]  scan_idx_ff;
   logic [IW-1:0] chk_idx_ff;
   logic         chk_v_ff;
   logic         slot_found_ff;
   logic [IW-1:0] slot_ff;

   etype_type    em_type_ff;
   pack_type     em_pack_ff;

   ms_type       last_any_ff;
   ms_type       last_type_ff [EVENT_TYPES];
   ms_type       drop_ff;

   logic         hold_v_ff;
   etype_type    hold_type_ff;
   pack_type     hold_pack_ff;
   logic         hold_nf_ff;
   ms_type       hold_drop_ff;

   logic         out_v_ff;
   etype_type    out_type_ff;
   pack_type     out_pack_ff;
   sev_type      out_sev_ff;
   logic         out_nf_ff;
   ms_type       out_drop_ff;
   logic         out_last_ff;

   logic         out_free, accept, out_load;
   logic         pv_chk, hit_flush, hit_clear, dup_begin, scan_issue, scan_done;
   logic         type_ok, g_ok, t_ok, nf;
   ms_type       lt;

   assign out_free  = !out_v_ff || rsp_ch.ready;
   assign accept    = req_ch.valid && req_ch.ready;
   assign out_load  = hold_v_ff && out_free && (state_ff == ST_EMIT || state_ff == ST_FINISH);
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.alert_type    = out_type_ff;
   assign rsp_ch.alert_pack    = out_pack_ff;
   assign rsp_ch.severity      = out_sev_ff;
   assign rsp_ch.notify        = out_nf_ff;
   assign rsp_ch.dropped_total = out_drop_ff;
   assign rsp_ch.last          = out_last_ff;

   // slot compare unit
   assign pv_chk     = chk_v_ff && pv_ff[chk_idx_ff];
   assign hit_flush  = pv_chk && ((now_ff - rd_ff.start) >= deb_ms_ff);
   assign hit_clear  = pv_chk && (rd_ff.etype == pb_ff) && (rd_ff.pack == pack_ff);
   assign dup_begin  = pv_chk && (rd_ff.etype == ty_ff) && (rd_ff.pack == pack_ff);
   assign scan_issue = (scan_idx_ff != SLOT_END);
   assign scan_done  = !chk_v_ff && !scan_issue;

   // rate limit unit
   assign type_ok = (32'(em_type_ff) < EVENT_TYPES);
   assign lt      = type_ok ? last_type_ff[em_type_ff[TW-1:0]] : '0;
   assign g_ok    = (last_any_ff == '0) || ((now_ff - last_any_ff) >= gap_ms_ff);
   assign t_ok    = (lt == '0) || ((now_ff - lt) >= cool_ms_ff);
   assign nf      = enable_ff && mask_ff[em_type_ff] && g_ok && t_ok;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.kind) begin
                  if (deb_ms_ff != '0) state_in = ST_SCAN;
               end else if (req_ch.event_type != '0 && req_ch.event_type <= MAX_TYPE) begin
                  if (begin_of(req_ch.event_type) != '0 || deb_ms_ff != '0)
                     state_in = ST_SCAN;
                  else
                     state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            case (mode_ff)
               MODE_FLUSH: begin
                  if (hit_flush) state_in = ST_EMIT;
                  else if (scan_done) state_in = ST_FINISH;
               end
               MODE_CLEAR: begin
                  if (hit_clear) state_in = ST_FINISH;
                  else if (scan_done) state_in = ST_EMIT;
               end
               default: begin
                  if (dup_begin || scan_done) state_in = ST_FINISH;
               end
            endcase
         end
         ST_EMIT: begin
            if (!hold_v_ff || out_free)
               state_in = (mode_ff == MODE_FLUSH) ? ST_SCAN : ST_FINISH;
         end
         ST_FINISH: begin
            if (!hold_v_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // pending memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      rd_ff <= mem[scan_idx_ff[IW-1:0]];
      if (state_ff == ST_SCAN && mode_ff == MODE_BEGIN && scan_done && slot_found_ff)
         mem[slot_ff] <= '{etype: ty_ff, pack: pack_ff, start: now_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         deb_ms_ff   <= '0;
         gap_ms_ff   <= FLOOR_MS;
         cool_ms_ff  <= FLOOR_MS;
         mask_ff     <= '0;
         enable_ff   <= 1'b0;
         pv_ff       <= '0;
         chk_v_ff    <= 1'b0;
         hold_v_ff   <= 1'b0;
         out_v_ff    <= 1'b0;
         last_any_ff <= '0;
         drop_ff     <= '0;
         for (int i = 0; i < EVENT_TYPES; i++) last_type_ff[i] <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_ch.valid) begin
            case (csr_ch.index)
               REG_DEBOUNCE: deb_ms_ff <= 32'(csr_ch.data[11:0]) * MS_PER_S;
               REG_GLOBAL:   gap_ms_ff <= (csr_ch.data[16:0] >= FLOOR_S) ?
                                          32'(csr_ch.data[16:0]) * MS_PER_S : FLOOR_MS;
               REG_COOLDOWN: cool_ms_ff <= (csr_ch.data[16:0] >= FLOOR_S) ?
                                           32'(csr_ch.data[16:0]) * MS_PER_S : FLOOR_MS;
               REG_MASK:     mask_ff <= csr_ch.data[17:0];
               REG_ENABLE:   enable_ff <= csr_ch.data[0];
               default: ;
            endcase
         end

         if (out_v_ff && rsp_ch.ready && !out_load) out_v_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ty_ff         <= req_ch.event_type;
                  pack_ff       <= req_ch.pack_id;
                  now_ff        <= req_ch.now_ms;
                  pb_ff         <= begin_of(req_ch.event_type);
                  em_type_ff    <= req_ch.event_type;
                  em_pack_ff    <= req_ch.pack_id;
                  scan_idx_ff   <= '0;
                  chk_v_ff      <= 1'b0;
                  slot_found_ff <= 1'b0;
                  if (req_ch.kind)
                     mode_ff <= MODE_FLUSH;
                  else if (begin_of(req_ch.event_type) != '0)
                     mode_ff <= MODE_CLEAR;
                  else if (deb_ms_ff != '0)
                     mode_ff <= MODE_BEGIN;
                  else
                     mode_ff <= MODE_SINGLE;
               end
            end
            ST_SCAN: begin
               if (state_in == ST_SCAN) begin
                  chk_v_ff   <= scan_issue;
                  chk_idx_ff <= scan_idx_ff[IW-1:0];
                  if (scan_issue) scan_idx_ff <= scan_idx_ff + 1'b1;
               end else begin
                  chk_v_ff <= 1'b0;
               end
               case (mode_ff)
                  MODE_FLUSH: begin
                     if (hit_flush) begin
                        pv_ff[chk_idx_ff] <= 1'b0;
                        em_type_ff  <= rd_ff.etype;
                        em_pack_ff  <= rd_ff.pack;
                        scan_idx_ff <= {1'b0, chk_idx_ff} + 1'b1;
                     end
                  end
                  MODE_CLEAR: begin
                     if (hit_clear) pv_ff[chk_idx_ff] <= 1'b0;
                  end
                  default: begin
                     if (chk_v_ff && !pv_ff[chk_idx_ff] && !slot_found_ff) begin
                        slot_found_ff <= 1'b1;
                        slot_ff       <= chk_idx_ff;
                     end
                     if (scan_done) begin
                        if (slot_found_ff) pv_ff[slot_ff] <= 1'b1;
                        else drop_ff <= drop_ff + 1'b1;
                     end
                  end
               endcase
            end
            ST_EMIT: begin
               if (!hold_v_ff || out_free) begin
                  if (hold_v_ff) begin
                     out_v_ff    <= 1'b1;
                     out_type_ff <= hold_type_ff;
                     out_pack_ff <= hold_pack_ff;
                     out_sev_ff  <= sev_of(hold_type_ff);
                     out_nf_ff   <= hold_nf_ff;
                     out_drop_ff <= hold_drop_ff;
                     out_last_ff <= 1'b0;
                  end
                  hold_v_ff    <= 1'b1;
                  hold_type_ff <= em_type_ff;
                  hold_pack_ff <= em_pack_ff;
                  hold_nf_ff   <= nf;
                  hold_drop_ff <= drop_ff;
                  if (nf) begin
                     last_any_ff <= now_ff;
                     if (type_ok) last_type_ff[em_type_ff[TW-1:0]] <= now_ff;
                  end
               end
            end
            ST_FINISH: begin
               if (hold_v_ff && out_free) begin
                  out_v_ff    <= 1'b1;
                  out_type_ff <= hold_type_ff;
                  out_pack_ff <= hold_pack_ff;
                  out_sev_ff  <= sev_of(hold_type_ff);
                  out_nf_ff   <= hold_nf_ff;
                  out_drop_ff <= hold_drop_ff;
                  out_last_ff <= 1'b1;
                  hold_v_ff   <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// File: test/alert_flap_debounce_rate_limiter_test.sv
// Self-checking testbench for the alert debounce table and notification rate limiter.
// Depends on afdrl_pkg, the channel interfaces in afdrl_if.sv and the top level.
module alert_flap_debounce_rate_limiter_test;
   import afdrl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 32;
   localparam int NTYPES = 18;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 120;

   typedef struct packed {
      logic      kind;
      etype_type event_type;
      pack_type  pack_id;
      ms_type    now_ms;
   } event_item_t;

   typedef struct packed {
      etype_type alert_type;
      pack_type  alert_pack;
      sev_type   severity;
      logic      notify;
      ms_type    dropped_total;
      logic      last;
   } alert_t;

   typedef struct packed {
      reg_index_type index;
      csr_data_type  data;
   } reg_write_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   afdrl_req_if req_if();
   afdrl_rsp_if rsp_if();
   afdrl_csr_if csr_if();

   alert_flap_debounce_rate_limiter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // stimulus and expectation stores
   event_item_t event_q[$];
   reg_write_t  reg_q[$];
   alert_t      alert_q[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_req_cnt = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int errors = 0;
   int alerts_seen = 0;
   int events_sent = 0;
   int quiet_cycles = 0;
   ms_type now_t = '0;

   // shadow of the block's registers and state
   logic [11:0] m_debounce;
   logic [16:0] m_global;
   logic [16:0] m_cooldown;
   logic [17:0] m_mask;
   logic        m_enable;
   logic        m_valid [SLOTS];
   etype_type   m_type [SLOTS];
   pack_type    m_pack [SLOTS];
   ms_type      m_start [SLOTS];
   ms_type      m_last_any;
   ms_type      m_last_type [NTYPES];
   ms_type      m_drops;

   function automatic sev_type severity_for(etype_type t);
      case (t)
         5'd3, 5'd5, 5'd7, 5'd15, 5'd16: return 2'd2;
         5'd1, 5'd9, 5'd11, 5'd13:       return 2'd1;
         default:                        return 2'd0;
      endcase
   endfunction

   // begin type a clear cancels, zero for begins
   function automatic etype_type cancelled_begin(etype_type t);
      if (t == 5'd17) return 5'd16;
      if (t >= 5'd2 && t <= 5'd14 && !t[0]) return t - 5'd1;
      return 5'd0;
   endfunction

   function automatic alert_t fire_alert(etype_type t, pack_type p, ms_type now);
      alert_t a;
      ms_type gap, cool, lt;
      logic g_ok, t_ok;
      a.alert_type = t;
      a.alert_pack = p;
      a.severity = severity_for(t);
      a.notify = 1'b0;
      a.dropped_total = m_drops;
      a.last = 1'b0;
      if (m_enable && m_mask[t]) begin
         gap = (m_global >= 17'd60) ? ms_type'(32'(m_global) * 32'd1000) : 32'd60000;
         cool = (m_cooldown >= 17'd60) ? ms_type'(32'(m_cooldown) * 32'd1000) : 32'd60000;
         lt = m_last_type[t];
         g_ok = (m_last_any == 0) || (ms_type'(now - m_last_any) >= gap);
         t_ok = (lt == 0) || (ms_type'(now - lt) >= cool);
         if (g_ok && t_ok) begin
            a.notify = 1'b1;
            m_last_any = now;
            m_last_type[t] = now;
         end
      end
      return a;
   endfunction

   function automatic void predict_alerts(event_item_t it);
      ms_type deb_ms;
      etype_type pb;
      int slot, n;
      deb_ms = ms_type'(32'(m_debounce) * 32'd1000);
      n = 0;
      if (it.kind) begin
         if (deb_ms == 0) return;
         for (int i = 0; i < SLOTS; i++) begin
            if (m_valid[i] && ms_type'(it.now_ms - m_start[i]) >= deb_ms) begin
               m_valid[i] = 1'b0;
               alert_q.push_back(fire_alert(m_type[i], m_pack[i], it.now_ms));
               n++;
            end
         end
      end else begin
         if (it.event_type == 0 || it.event_type > 5'd17) return;
         pb = cancelled_begin(it.event_type);
         if (pb != 0) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (m_valid[i] && m_type[i] == pb && m_pack[i] == it.pack_id) begin
                  m_valid[i] = 1'b0;
                  return;
               end
            end
            alert_q.push_back(fire_alert(it.event_type, it.pack_id, it.now_ms));
            n = 1;
         end else if (deb_ms == 0) begin
            alert_q.push_back(fire_alert(it.event_type, it.pack_id, it.now_ms));
            n = 1;
         end else begin
            slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (m_valid[i] && m_type[i] == it.event_type && m_pack[i] == it.pack_id) return;
               if (!m_valid[i] && slot < 0) slot = i;
            end
            if (slot >= 0) begin
               m_valid[slot] = 1'b1;
               m_type[slot] = it.event_type;
               m_pack[slot] = it.pack_id;
               m_start[slot] = it.now_ms;
            end else begin
               m_drops = m_drops + 1;
            end
            return;
         end
      end
      if (n > 0) alert_q[$].last = 1'b1;
   endfunction

   function automatic void apply_reg(reg_write_t w);
      case (w.index)
         REG_DEBOUNCE: m_debounce = w.data[11:0];
         REG_GLOBAL:   m_global = w.data[16:0];
         REG_COOLDOWN: m_cooldown = w.data[16:0];
         REG_MASK:     m_mask = w.data[17:0];
         REG_ENABLE:   m_enable = w.data[0];
         default: ;
      endcase
   endfunction

   initial begin
      m_debounce = '0;
      m_global = 17'd60;
      m_cooldown = 17'd60;
      m_mask = '0;
      m_enable = 1'b0;
      m_last_any = '0;
      m_drops = '0;
      for (int i = 0; i < SLOTS; i++) begin
         m_valid[i] = 1'b0;
         m_type[i] = '0;
         m_pack[i] = '0;
         m_start[i] = '0;
      end
      for (int i = 0; i < NTYPES; i++) m_last_type[i] = '0;
   end

   // event driver: predicts on each accepted transfer, then offers the next item
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.kind <= 1'b0;
         req_if.event_type <= '0;
         req_if.pack_id <= '0;
         req_if.now_ms <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_alerts({req_if.kind, req_if.event_type, req_if.pack_id, req_if.now_ms});
            events_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               {req_if.kind, req_if.event_type, req_if.pack_id, req_if.now_ms}
                  <= event_q.pop_front();
               req_if.valid <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // register write driver
   always @(posedge clock) begin
      if (reset) begin
         csr_if.valid <= 1'b0;
         csr_if.index <= '0;
         csr_if.data <= '0;
      end else begin
         if (csr_if.valid && csr_if.ready)
            apply_reg({reg_index_type'(csr_if.index), csr_if.data});
         if (!csr_if.valid || csr_if.ready) begin
            if (reg_q.size() != 0) begin
               {csr_if.index, csr_if.data} <= reg_q.pop_front();
               csr_if.valid <= 1'b1;
            end else begin
               csr_if.valid <= 1'b0;
            end
         end
      end
   end

   // alert monitor and receiver stall control
   always @(posedge clock) begin
      alert_t want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            alerts_seen++;
            if (alert_q.size() == 0) begin
               $error("unexpected alert type %0d pack %0d", rsp_if.alert_type, rsp_if.alert_pack);
               errors++;
            end else begin
               want = alert_q.pop_front();
               if (rsp_if.alert_type !== want.alert_type) begin
                  $error("alert_type: expected %0d, got %0d", want.alert_type, rsp_if.alert_type);
                  errors++;
               end
               if (rsp_if.alert_pack !== want.alert_pack) begin
                  $error("alert_pack: expected %0d, got %0d", want.alert_pack, rsp_if.alert_pack);
                  errors++;
               end
               if (rsp_if.severity !== want.severity) begin
                  $error("severity: expected %0d, got %0d", want.severity, rsp_if.severity);
                  errors++;
               end
               if (rsp_if.notify !== want.notify) begin
                  $error("notify: expected %0d, got %0d", want.notify, rsp_if.notify);
                  errors++;
               end
               if (rsp_if.dropped_total !== want.dropped_total) begin
                  $error("dropped_total: expected %0d, got %0d",
                         want.dropped_total, rsp_if.dropped_total);
                  errors++;
               end
               if (rsp_if.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_if.last);
                  errors++;
               end
            end
         end
         if (hold_seen != hold_req_cnt) begin
            hold_seen <= hold_req_cnt;
            hold_left <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_event(logic k, etype_type t, pack_type p, ms_type now);
      event_q.push_back({k, t, p, now});
   endtask

   task automatic write_reg(reg_index_type idx, csr_data_type value);
      reg_q.push_back({idx, value});
   endtask

   // wait for all traffic to drain, then for the block to finish silent items
   task automatic settle();
      do @(posedge clock);
      while (event_q.size() != 0 || req_if.valid || alert_q.size() != 0
             || reg_q.size() != 0 || csr_if.valid);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic pack_type pick_pack();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd255;
         default: return pack_type'($urandom_range(255));
      endcase
   endfunction

   task automatic random_events(int count, int max_step);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if ($urandom_range(19) == 0) now_t = $urandom;
         else now_t = now_t + $urandom_range(max_step);
         if (r < 18) begin
            push_event(1'b1, etype_type'($urandom_range(31)), pick_pack(), now_t);
         end else if (r < 24) begin
            push_event(1'b0, ($urandom_range(1) ? 5'd0 : etype_type'($urandom_range(31, 18))),
                       pick_pack(), now_t);
         end else if (r < 62) begin
            // begins: odd types up to 15, plus 16
            push_event(1'b0, ($urandom_range(8) == 8) ? 5'd16
                       : etype_type'(2 * $urandom_range(7) + 1), pick_pack(), now_t);
         end else begin
            push_event(1'b0, ($urandom_range(7) == 7) ? 5'd17
                       : etype_type'(2 * $urandom_range(7, 1)), pick_pack(), now_t);
         end
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: immediate firing, floors at their minimum, all types notifiable
      send_idle_pct = 18;
      recv_idle_pct = 47;
      write_reg(REG_GLOBAL, 32'd0);
      write_reg(REG_COOLDOWN, 32'd0);
      write_reg(REG_MASK, 32'h3FFFF);
      write_reg(REG_ENABLE, 32'd1);
      settle();
      push_event(1'b0, 5'd0, 8'd5, 32'd0);
      push_event(1'b0, 5'd31, 8'd5, 32'd0);
      push_event(1'b0, 5'd18, 8'd5, 32'd0);
      push_event(1'b0, 5'd1, 8'd255, 32'd0);       // notify stamped at time zero
      for (int t = 2; t <= 17; t++) push_event(1'b0, etype_type'(t), pack_type'(t * 15),
                                                32'd70000 * t);
      push_event(1'b1, 5'd0, 8'd0, 32'hFFFF_FFFF);  // flush with no debounce
      settle();
      write_reg(REG_DEBOUNCE, 32'd1);
      settle();
      now_t = 32'hFFFF_FF00;
      push_event(1'b0, 5'd1, 8'd3, now_t);
      push_event(1'b0, 5'd1, 8'd3, now_t);          // duplicate begin
      push_event(1'b0, 5'd2, 8'd3, now_t);          // clear cancels its begin
      push_event(1'b0, 5'd5, 8'd7, now_t);
      push_event(1'b1, 5'd0, 8'd0, now_t + 500);
      now_t = now_t + 1000;                        // wraps past zero
      push_event(1'b1, 5'd0, 8'd0, now_t);
      settle();

      // random, sender idles lightly and receiver heavily
      write_reg(REG_GLOBAL, 32'd60);
      write_reg(REG_COOLDOWN, 32'd120);
      write_reg(REG_MASK, $urandom_range(32'h3FFFF));
      settle();
      random_events(50, 40000);
      settle();

      // table overflow and a full flush, receiver idles lightly
      send_idle_pct = 47;
      recv_idle_pct = 18;
      write_reg(REG_DEBOUNCE, 32'd2);
      write_reg(REG_GLOBAL, 32'd131071);
      write_reg(REG_COOLDOWN, 32'd0);
      write_reg(REG_MASK, 32'h3FFFF);
      settle();
      now_t = $urandom;
      for (int p = 0; p < 36; p++) push_event(1'b0, 5'd15, pack_type'(p), now_t);
      now_t = now_t + 2000;
      push_event(1'b1, 5'd0, 8'd0, now_t);
      random_events(20, 3000);
      settle();

      // no idling, long windows and notification off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(REG_DEBOUNCE, 32'd4095);
      write_reg(REG_GLOBAL, 32'd86400);
      write_reg(REG_COOLDOWN, 32'd86400);
      write_reg(REG_ENABLE, 32'd0);
      settle();
      random_events(25, 32'd5_000_000);
      settle();

      // receiver holds off while immediate events keep coming
      write_reg(REG_DEBOUNCE, 32'd0);
      write_reg(REG_ENABLE, 32'd1);
      write_reg(REG_GLOBAL, 32'd0);
      write_reg(REG_COOLDOWN, 32'd61);
      write_reg(REG_MASK, $urandom_range(32'h3FFFF));
      settle();
      hold_req_cnt++;
      random_events(15, 70000);
      settle();

      $display("Covered %0d accepted events and %0d checked alerts,", events_sent, alerts_seen);
      $display("  across debounce, cancel, overflow, flush and rate limit settings.");
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
